FILE: hw/rtl/midi_track_event_parser_core_assert.svh
// assertion macros shared by the parser rtl
`ifndef MIDI_TRACK_EVENT_PARSER_CORE_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define MTEP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mtep assertion failed");

// next-cycle implication, checked only out of reset
`define MTEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mtep assertion failed");

`endif

FILE: hw/rtl/mtep_pkg.sv
package mtep_pkg;

    localparam int unsigned QTY_W = 28;

    typedef enum logic [2:0] {
        PH_DELTA  = 3'd0,
        PH_STATUS = 3'd1,
        PH_META   = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    localparam logic [2:0] ROLE_DELTA  = 3'd0;
    localparam logic [2:0] ROLE_STATUS = 3'd1;
    localparam logic [2:0] ROLE_META   = 3'd2;
    localparam logic [2:0] ROLE_LEN    = 3'd3;
    localparam logic [2:0] ROLE_DATA   = 3'd4;
    localparam logic [2:0] ROLE_SKIP   = 3'd5;

    localparam logic [1:0] KIND_CHAN  = 2'd0;
    localparam logic [1:0] KIND_SYSF0 = 2'd1;
    localparam logic [1:0] KIND_SYSF7 = 2'd2;
    localparam logic [1:0] KIND_META  = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_NO_RUN    = 2'd2;
    localparam logic [1:0] ERR_UNDEFINED = 2'd3;

    localparam logic [7:0] STATUS_MIN    = 8'h80;
    localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
    localparam logic [7:0] STATUS_SYSF0  = 8'hF0;
    localparam logic [7:0] STATUS_SYSF7  = 8'hF7;
    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [7:0] META_END_TRACK = 8'h2F;

    // program change and channel pressure carry one data byte, the rest two
    function automatic logic [1:0] chan_len(input logic [7:0] st);
        logic [1:0] len;
        len = (st >= 8'hC0 && st <= 8'hDF) ? 2'd1 : 2'd2;
        return len;
    endfunction

endpackage

FILE: hw/rtl/midi_track_event_parser_core.sv
// Track event parser for a standard midi file track body. One byte of the
// track body enters per item on the s_ channel and every byte gives exactly
// one result item on the m_ channel, which labels the byte (delta, status,
// meta type, length, data or skipped), carries the event's delta time,
// effective status, meta type and payload length, and flags event end, end
// of track (meta 2F) and errors. Running status is armed by channel messages
// and cancelled by sysex and meta events and by undefined status bytes. Any
// error drops the event and the next byte starts a new delta time. Rate: one
// byte per clock cycle sustained while m_ready keeps up; the result register
// loads on acceptance, and the single state update per byte (quantity shift-in,
// status decode, 28-bit payload position add) sits between the parser state
// registers and the result register. s_ready stays high while the result
// register is empty or being taken in the same cycle.
`include "midi_track_event_parser_core_assert.svh"

module midi_track_event_parser_core
    import mtep_pkg::*;
#(
    parameter int unsigned MAX_QUANTITY_BYTES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    // byte input
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_byte,
    // result output
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_byte_role,
    output logic [1:0]        m_event_kind,
    output logic [QTY_W-1:0]  m_delta_ticks,
    output logic [7:0]        m_status_value,
    output logic [7:0]        m_meta_kind,
    output logic [QTY_W-1:0]  m_payload_length,
    output logic [7:0]        m_payload_byte,
    output logic [QTY_W-1:0]  m_payload_index,
    output logic              m_event_done,
    output logic              m_track_end,
    output logic              m_running_used,
    output logic [1:0]        m_error_code
);

    // quantity byte counter only has to reach the byte limit
    localparam int unsigned CNT_W = $clog2(MAX_QUANTITY_BYTES + 1);

    // parser state
    phase_t             phase_reg, phase_next;
    logic [QTY_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [QTY_W-1:0]   held_delta_reg, held_delta_next;
    logic [7:0]         cur_status_reg, cur_status_next;
    logic [7:0]         rs_value_reg, rs_value_next;
    logic               rs_valid_reg, rs_valid_next;
    logic [1:0]         cur_kind_reg, cur_kind_next;
    logic [7:0]         cur_meta_reg, cur_meta_next;
    logic [QTY_W-1:0]   remain_reg, remain_next;
    logic [QTY_W-1:0]   pos_reg, pos_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [2:0]         role_reg, role_next;
    logic [1:0]         kind_reg, kind_next;
    logic [QTY_W-1:0]   delta_reg, delta_next;
    logic [7:0]         status_reg, status_next;
    logic [7:0]         meta_reg, meta_next;
    logic [QTY_W-1:0]   plen_reg, plen_next;
    logic [7:0]         pbyte_reg, pbyte_next;
    logic [QTY_W-1:0]   pidx_reg, pidx_next;
    logic               done_reg, done_next;
    logic               tend_reg, tend_next;
    logic               run_reg, run_next;
    logic [1:0]         err_reg, err_next;

    logic               s_fire;
    logic [7:0]         b;

    // shared decode of the incoming byte
    logic               qty_phase;
    logic [QTY_W-1:0]   acc_src;
    logic [CNT_W-1:0]   cnt_src;
    logic [QTY_W-1:0]   acc_shift;
    logic [CNT_W:0]     cnt_inc;
    logic               qty_too_long;
    logic               qty_last;
    logic [1:0]         rs_len;
    logic [1:0]         b_len;
    logic [QTY_W-1:0]   remain_dec;
    logic               is_end_track;
    logic               clear_event;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign b       = s_in_byte;

    // an unused phase code behaves as a fresh delta time
    assign qty_phase    = (phase_reg == PH_DELTA) || (phase_reg == PH_LEN);
    assign acc_src      = qty_phase ? acc_reg : '0;
    assign cnt_src      = qty_phase ? cnt_reg : '0;
    assign acc_shift    = {acc_src[QTY_W-8:0], b[6:0]};
    assign cnt_inc      = {1'b0, cnt_src} + (CNT_W + 1)'(1);
    assign qty_last     = !b[7];
    assign qty_too_long = b[7] && (cnt_inc >= (CNT_W + 1)'(MAX_QUANTITY_BYTES));
    assign rs_len       = chan_len(rs_value_reg);
    assign b_len        = chan_len(b);
    assign remain_dec   = (remain_reg != '0) ? remain_reg - QTY_W'(1) : remain_reg;
    assign is_end_track = (cur_kind_reg == KIND_META) && (cur_meta_reg == META_END_TRACK);

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_STATUS: begin
                if (b < STATUS_MIN) begin
                    if (!rs_valid_reg || rs_len == 2'd1) begin
                        phase_next = PH_DELTA;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else if (b < STATUS_SYSTEM) begin
                    phase_next = PH_DATA;
                end else if (b == STATUS_SYSF0 || b == STATUS_SYSF7) begin
                    phase_next = PH_LEN;
                end else if (b == STATUS_META) begin
                    phase_next = PH_META;
                end else begin
                    phase_next = PH_DELTA;
                end
            end
            PH_META: begin
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                if (qty_too_long) begin
                    phase_next = PH_DELTA;
                end else if (qty_last) begin
                    phase_next = (acc_shift == '0) ? PH_DELTA : PH_DATA;
                end
            end
            PH_DATA: begin
                if (remain_dec == '0) begin
                    phase_next = PH_DELTA;
                end
            end
            default: begin
                if (qty_too_long) begin
                    phase_next = PH_DELTA;
                end else if (qty_last) begin
                    phase_next = PH_STATUS;
                end else begin
                    phase_next = PH_DELTA;
                end
            end
        endcase
    end

    // event registers and result fields
    always_comb begin
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        held_delta_next = held_delta_reg;
        cur_status_next = cur_status_reg;
        rs_value_next   = rs_value_reg;
        rs_valid_next   = rs_valid_reg;
        cur_kind_next   = cur_kind_reg;
        cur_meta_next   = cur_meta_reg;
        remain_next     = remain_reg;
        pos_next        = pos_reg;
        clear_event     = 1'b0;

        role_next  = ROLE_DELTA;
        kind_next  = '0;
        delta_next = '0;
        status_next = '0;
        meta_next  = '0;
        plen_next  = '0;
        pbyte_next = '0;
        pidx_next  = '0;
        done_next  = 1'b0;
        tend_next  = 1'b0;
        run_next   = 1'b0;
        err_next   = ERR_NONE;

        unique case (phase_reg)
            PH_STATUS: begin
                if (b < STATUS_MIN) begin
                    if (!rs_valid_reg) begin
                        err_next    = ERR_NO_RUN;
                        clear_event = 1'b1;
                    end else begin
                        // running status turns this byte into the first data byte
                        cur_status_next = rs_value_reg;
                        cur_kind_next   = KIND_CHAN;
                        role_next       = ROLE_DATA;
                        kind_next       = KIND_CHAN;
                        delta_next      = held_delta_reg;
                        status_next     = rs_value_reg;
                        meta_next       = cur_meta_reg;
                        plen_next       = QTY_W'(rs_len);
                        pbyte_next      = b;
                        run_next        = 1'b1;
                        if (rs_len == 2'd1) begin
                            done_next   = 1'b1;
                            clear_event = 1'b1;
                        end else begin
                            remain_next = QTY_W'(1);
                            pos_next    = QTY_W'(1);
                        end
                    end
                end else if (b < STATUS_SYSTEM) begin
                    // channel message re-arms running status
                    cur_status_next = b;
                    cur_kind_next   = KIND_CHAN;
                    rs_value_next   = b;
                    rs_valid_next   = 1'b1;
                    remain_next     = QTY_W'(b_len);
                    pos_next        = '0;
                    role_next       = ROLE_STATUS;
                    kind_next       = KIND_CHAN;
                    delta_next      = held_delta_reg;
                    status_next     = b;
                    meta_next       = cur_meta_reg;
                    plen_next       = QTY_W'(b_len);
                end else if (b == STATUS_SYSF0 || b == STATUS_SYSF7 || b == STATUS_META) begin
                    rs_valid_next   = 1'b0;
                    cur_status_next = b;
                    if (b == STATUS_SYSF0) begin
                        cur_kind_next = KIND_SYSF0;
                    end else if (b == STATUS_SYSF7) begin
                        cur_kind_next = KIND_SYSF7;
                    end else begin
                        cur_kind_next = KIND_META;
                    end
                    acc_next    = '0;
                    cnt_next    = '0;
                    role_next   = ROLE_STATUS;
                    kind_next   = cur_kind_next;
                    delta_next  = held_delta_reg;
                    status_next = b;
                    meta_next   = cur_meta_reg;
                end else begin
                    rs_valid_next = 1'b0;
                    err_next      = ERR_UNDEFINED;
                    clear_event   = 1'b1;
                end
            end
            PH_META: begin
                cur_meta_next = b;
                acc_next      = '0;
                cnt_next      = '0;
                role_next     = ROLE_META;
                kind_next     = cur_kind_reg;
                delta_next    = held_delta_reg;
                status_next   = cur_status_reg;
                meta_next     = b;
            end
            PH_LEN: begin
                if (qty_too_long) begin
                    err_next    = ERR_TOO_LONG;
                    clear_event = 1'b1;
                end else begin
                    acc_next    = acc_shift;
                    cnt_next    = cnt_inc[CNT_W-1:0];
                    role_next   = ROLE_LEN;
                    kind_next   = cur_kind_reg;
                    delta_next  = held_delta_reg;
                    status_next = cur_status_reg;
                    meta_next   = cur_meta_reg;
                    plen_next   = acc_shift;
                    if (qty_last) begin
                        if (acc_shift == '0) begin
                            // zero-length event ends on its last length byte
                            done_next   = 1'b1;
                            tend_next   = is_end_track;
                            clear_event = 1'b1;
                        end else begin
                            remain_next = acc_shift;
                            pos_next    = '0;
                        end
                    end
                end
            end
            PH_DATA: begin
                role_next   = ROLE_DATA;
                kind_next   = cur_kind_reg;
                delta_next  = held_delta_reg;
                status_next = cur_status_reg;
                meta_next   = cur_meta_reg;
                plen_next   = pos_reg + remain_reg;
                pbyte_next  = b;
                pidx_next   = pos_reg;
                pos_next    = pos_reg + QTY_W'(1);
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    done_next   = 1'b1;
                    tend_next   = is_end_track;
                    clear_event = 1'b1;
                end
            end
            default: begin
                // delta time, also the start after a dropped or finished event
                held_delta_next = '0;
                cur_status_next = '0;
                cur_kind_next   = '0;
                cur_meta_next   = '0;
                remain_next     = '0;
                pos_next        = '0;
                if (qty_too_long) begin
                    err_next    = ERR_TOO_LONG;
                    clear_event = 1'b1;
                end else begin
                    role_next  = ROLE_DELTA;
                    delta_next = acc_shift;
                    if (qty_last) begin
                        held_delta_next = acc_shift;
                        acc_next        = '0;
                        cnt_next        = '0;
                    end else begin
                        acc_next = acc_shift;
                        cnt_next = cnt_inc[CNT_W-1:0];
                    end
                end
            end
        endcase

        if (err_next != ERR_NONE) begin
            // a dropped byte reports only its error, as a skipped byte that ends the event
            role_next   = ROLE_SKIP;
            kind_next   = '0;
            delta_next  = '0;
            status_next = '0;
            meta_next   = '0;
            plen_next   = '0;
            pbyte_next  = '0;
            pidx_next   = '0;
            done_next   = 1'b1;
            tend_next   = 1'b0;
            run_next    = 1'b0;
        end

        if (clear_event) begin
            acc_next        = '0;
            cnt_next        = '0;
            held_delta_next = '0;
            cur_status_next = '0;
            cur_kind_next   = '0;
            cur_meta_next   = '0;
            remain_next     = '0;
            pos_next        = '0;
        end
    end

    assign m_valid_next = s_fire || (m_valid_reg && !m_ready);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_DELTA;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            held_delta_reg <= '0;
            cur_status_reg <= '0;
            rs_value_reg   <= '0;
            rs_valid_reg   <= 1'b0;
            cur_kind_reg   <= '0;
            cur_meta_reg   <= '0;
            remain_reg     <= '0;
            pos_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                cnt_reg        <= cnt_next;
                held_delta_reg <= held_delta_next;
                cur_status_reg <= cur_status_next;
                rs_value_reg   <= rs_value_next;
                rs_valid_reg   <= rs_valid_next;
                cur_kind_reg   <= cur_kind_next;
                cur_meta_reg   <= cur_meta_next;
                remain_reg     <= remain_next;
                pos_reg        <= pos_next;
            end
        end
    end

    // result payload, loaded on every accepted byte
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            role_reg   <= role_next;
            kind_reg   <= kind_next;
            delta_reg  <= delta_next;
            status_reg <= status_next;
            meta_reg   <= meta_next;
            plen_reg   <= plen_next;
            pbyte_reg  <= pbyte_next;
            pidx_reg   <= pidx_next;
            done_reg   <= done_next;
            tend_reg   <= tend_next;
            run_reg    <= run_next;
            err_reg    <= err_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_byte_role      = role_reg;
    assign m_event_kind     = kind_reg;
    assign m_delta_ticks    = delta_reg;
    assign m_status_value   = status_reg;
    assign m_meta_kind      = meta_reg;
    assign m_payload_length = plen_reg;
    assign m_payload_byte   = pbyte_reg;
    assign m_payload_index  = pidx_reg;
    assign m_event_done     = done_reg;
    assign m_track_end      = tend_reg;
    assign m_running_used   = run_reg;
    assign m_error_code     = err_reg;

    // an error item is always a skipped byte that closes the event
    `MTEP_ASSERT_IMPLY(a_err_skip, aclk, aresetn, m_valid && (m_error_code != ERR_NONE), (m_byte_role == ROLE_SKIP) && m_event_done)

    // end of track is only reported on the byte that closes the event
    `MTEP_ASSERT_IMPLY(a_tend_done, aclk, aresetn, m_valid && m_track_end, m_event_done && (m_event_kind == KIND_META))

    // running status only ever produces a channel data byte
    `MTEP_ASSERT_IMPLY(a_run_data, aclk, aresetn, m_valid && m_running_used, (m_byte_role == ROLE_DATA) && m_status_value[7] && (m_event_kind == KIND_CHAN))

    // a dropped or finished event restarts at delta time
    `MTEP_ASSERT_NEXT(a_restart, aclk, aresetn, s_fire && done_next, phase_reg == PH_DELTA)

endmodule
